/* rtl/assert_macros.svh */
// assertion helpers for the rtl, included by pfc_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define CHECK_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/pfc_pkg.sv */
package pfc_pkg;

  localparam int unsigned FmtFirst = 7;
  localparam int unsigned FmtLast  = 32;
  localparam logic [16:0] FullScale = 17'd65535;

  typedef enum logic [1:0] {
    KIND_PACKED = 2'd0,
    KIND_ARR8   = 2'd1,
    KIND_ARR16  = 2'd2
  } kind_t;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_SRC_FMT  = 2'd0,
    REG_DST_FMT  = 2'd1,
    REG_SRC_NOA  = 2'd2,
    REG_DST_NOA  = 2'd3
  } reg_idx_t;

  // mask codes: each mask is (1 << width) - 1
  typedef logic [4:0] mwidth_t;

  typedef struct packed {
    logic          ok;
    logic [2:0]    chans;
    logic [3:0]    size;
    mwidth_t [3:0] wid;
    logic [5:0][3:0] off_dummy;
  } layout_unused_t;

  // per-channel field: bit offset and field width
  typedef struct packed {
    logic [5:0] off;
    mwidth_t    wid;
  } field_t;

  typedef struct packed {
    logic         valid;
    logic [2:0]   chans;
    logic [3:0]   size;
    field_t [3:0] fld;
  } layout_t;

  function automatic field_t mk(input int unsigned off, input int unsigned wid);
    field_t f;
    f.off = 6'(off);
    f.wid = 5'(wid);
    return f;
  endfunction

  // format table, bit offsets already resolved
  function automatic layout_t lookup(input logic [5:0] fmt);
    layout_t l;
    l.valid = 1'b1;
    l.chans = 3'd4;
    l.size  = 4'd4;
    l.fld   = '0;
    case (fmt)
      6'd7: begin l.chans = 3'd1; l.size = 4'd1; l.fld[0] = mk(0, 8); end
      6'd8: begin l.chans = 3'd1; l.size = 4'd2; l.fld[0] = mk(0, 16); end
      6'd9: begin
        l.fld[0] = mk(16, 8); l.fld[1] = mk(8, 8); l.fld[2] = mk(0, 8); l.fld[3] = mk(24, 8);
      end
      6'd10: begin
        l.size = 4'd8;
        l.fld[0] = mk(32, 16); l.fld[1] = mk(16, 16); l.fld[2] = mk(0, 16);
        l.fld[3] = mk(48, 16);
      end
      6'd11: begin
        l.chans = 3'd3; l.size = 4'd2;
        l.fld[0] = mk(11, 5); l.fld[1] = mk(5, 6); l.fld[2] = mk(0, 5);
      end
      6'd12: begin
        l.chans = 3'd3; l.size = 4'd2;
        l.fld[0] = mk(0, 5); l.fld[1] = mk(5, 6); l.fld[2] = mk(11, 5);
      end
      6'd13: begin
        l.size = 4'd2;
        l.fld[0] = mk(11, 5); l.fld[1] = mk(6, 5); l.fld[2] = mk(1, 5); l.fld[3] = mk(0, 1);
      end
      6'd14: begin
        l.size = 4'd2;
        l.fld[0] = mk(1, 5); l.fld[1] = mk(6, 5); l.fld[2] = mk(11, 5); l.fld[3] = mk(0, 1);
      end
      6'd15: begin
        l.size = 4'd2;
        l.fld[0] = mk(10, 5); l.fld[1] = mk(5, 5); l.fld[2] = mk(0, 5); l.fld[3] = mk(15, 1);
      end
      6'd16: begin
        l.size = 4'd2;
        l.fld[0] = mk(0, 5); l.fld[1] = mk(5, 5); l.fld[2] = mk(10, 5); l.fld[3] = mk(15, 1);
      end
      6'd17: begin
        l.chans = 3'd3; l.size = 4'd3;
        l.fld[0] = mk(0, 8); l.fld[1] = mk(8, 8); l.fld[2] = mk(16, 8);
      end
      6'd18: begin
        l.chans = 3'd3; l.size = 4'd3;
        l.fld[0] = mk(16, 8); l.fld[1] = mk(8, 8); l.fld[2] = mk(0, 8);
      end
      6'd19: begin
        l.fld[0] = mk(0, 8); l.fld[1] = mk(8, 8); l.fld[2] = mk(16, 8); l.fld[3] = mk(24, 8);
      end
      6'd20: begin
        l.fld[0] = mk(16, 8); l.fld[1] = mk(8, 8); l.fld[2] = mk(0, 8); l.fld[3] = mk(24, 8);
      end
      6'd21: begin
        l.fld[0] = mk(8, 8); l.fld[1] = mk(16, 8); l.fld[2] = mk(24, 8); l.fld[3] = mk(0, 8);
      end
      6'd22: begin
        l.fld[0] = mk(24, 8); l.fld[1] = mk(16, 8); l.fld[2] = mk(8, 8); l.fld[3] = mk(0, 8);
      end
      6'd23: begin
        l.chans = 3'd3; l.size = 4'd6;
        l.fld[0] = mk(0, 16); l.fld[1] = mk(16, 16); l.fld[2] = mk(32, 16);
      end
      6'd24: begin
        l.chans = 3'd3; l.size = 4'd6;
        l.fld[0] = mk(32, 16); l.fld[1] = mk(16, 16); l.fld[2] = mk(0, 16);
      end
      6'd25: begin
        l.size = 4'd8;
        l.fld[0] = mk(0, 16); l.fld[1] = mk(16, 16); l.fld[2] = mk(32, 16);
        l.fld[3] = mk(48, 16);
      end
      6'd26: begin
        l.size = 4'd8;
        l.fld[0] = mk(32, 16); l.fld[1] = mk(16, 16); l.fld[2] = mk(0, 16);
        l.fld[3] = mk(48, 16);
      end
      6'd27: begin
        l.size = 4'd8;
        l.fld[0] = mk(16, 16); l.fld[1] = mk(32, 16); l.fld[2] = mk(48, 16);
        l.fld[3] = mk(0, 16);
      end
      6'd28: begin
        l.size = 4'd8;
        l.fld[0] = mk(48, 16); l.fld[1] = mk(32, 16); l.fld[2] = mk(16, 16);
        l.fld[3] = mk(0, 16);
      end
      6'd29: begin
        l.fld[0] = mk(22, 10); l.fld[1] = mk(12, 10); l.fld[2] = mk(2, 10); l.fld[3] = mk(0, 2);
      end
      6'd30: begin
        l.fld[0] = mk(2, 10); l.fld[1] = mk(12, 10); l.fld[2] = mk(22, 10); l.fld[3] = mk(0, 2);
      end
      6'd31: begin
        l.fld[0] = mk(20, 10); l.fld[1] = mk(10, 10); l.fld[2] = mk(0, 10); l.fld[3] = mk(30, 2);
      end
      6'd32: begin
        l.fld[0] = mk(0, 10); l.fld[1] = mk(10, 10); l.fld[2] = mk(20, 10); l.fld[3] = mk(30, 2);
      end
      default: begin l.valid = 1'b0; l.chans = 3'd0; l.size = 4'd0; end
    endcase
    return l;
  endfunction

  function automatic logic [15:0] wmask(input mwidth_t w);
    return 16'((17'd1 << w) - 17'd1);
  endfunction

  // (v * 65535) / mask with mask = 2^w - 1: replicate the field bits, then
  // drop one where the pattern after bit 16 (v rotated) is below v itself
  function automatic logic [15:0] expand(input logic [15:0] v, input mwidth_t w);
    logic [15:0] r;
    logic [15:0] rot;
    r = '0;
    rot = v;
    case (w)
      5'd1:  r = {16{v[0]}};
      5'd2:  r = {8{v[1:0]}};
      5'd5: begin
        r = {v[4:0], v[4:0], v[4:0], v[4]};
        rot = {11'd0, v[3:0], v[4]};
      end
      5'd6: begin
        r = {v[5:0], v[5:0], v[5:2]};
        rot = {10'd0, v[1:0], v[5:2]};
      end
      5'd8:  r = {v[7:0], v[7:0]};
      5'd10: begin
        r = {v[9:0], v[9:4]};
        rot = {6'd0, v[3:0], v[9:4]};
      end
      5'd16: r = v;
      default: r = '0;
    endcase
    if (rot < v) begin
      r = r - 16'd1;
    end
    return r;
  endfunction

endpackage

/* rtl/pfc_stream_if.sv */
interface pfc_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] pixel;
  logic        last;
  modport source (output valid, output pixel, output last, input ready);
  modport sink (input valid, input pixel, input last, output ready);
endinterface

/* rtl/pfc_front.sv */
// front: decodes source fields into four 16-bit channels, pushes a queue entry
module pfc_front (
  input  logic clk,
  input  logic rst,
  input  logic [5:0] source_format,
  input  logic [5:0] target_format,
  input  logic source_no_alpha,
  input  logic target_no_alpha,
  pfc_stream_if.sink in_ch,
  input  logic q_ready,
  output logic q_valid,
  output logic [65:0] q_data
);
  import pfc_pkg::*;

  layout_t sl;
  layout_t tl;
  logic [3:0][15:0] ch;
  logic [63:0] raw;
  logic ok;
  logic force_a;

  always_comb begin
    sl = lookup(source_format);
    tl = lookup(target_format);
    ok = sl.valid && tl.valid;
    raw = (sl.size >= 4'd8) ? in_ch.pixel :
          (in_ch.pixel & ((64'd1 << {sl.size[2:0], 3'b000}) - 64'd1));
    force_a = source_no_alpha || target_no_alpha || (sl.chans < 3'd4) || (tl.chans < 3'd4);
    for (int c = 0; c < 4; c++) begin
      if (3'(c) < sl.chans) begin
        ch[c] = expand(16'(raw >> sl.fld[c].off) & wmask(sl.fld[c].wid), sl.fld[c].wid);
      end else begin
        ch[c] = '0;
      end
    end
    if (force_a) begin
      ch[3] = 16'hFFFF;
    end
  end

  // one registered stage ahead of the queue
  logic        v;
  logic [65:0] d;
  assign in_ch.ready = !v || q_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ch.ready) begin
      v <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      d <= {in_ch.last, ok, ch};
    end
  end
  assign q_valid = v;
  assign q_data = d;
endmodule

/* rtl/pfc_fifo.sv */
// two-entry queue between front and back
module pfc_fifo (
  input  logic clk,
  input  logic rst,
  input  logic wvalid,
  output logic wready,
  input  logic [65:0] wdata,
  output logic rvalid,
  input  logic rready,
  output logic [65:0] rdata
);
  logic [1:0][65:0] mem;
  logic wp;
  logic rp;
  logic [1:0] cnt;

  assign wready = cnt != 2'd2;
  assign rvalid = cnt != 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (wvalid && wready) begin
        wp <= !wp;
      end
      if (rvalid && rready) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'((wvalid && wready) ? 1 : 0) - 2'((rvalid && rready) ? 1 : 0);
    end
    if (wvalid && wready) begin
      mem[wp] <= wdata;
    end
  end
endmodule

/* rtl/pfc_back.sv */
// back: encodes the channels into the target layout, output register
module pfc_back (
  input  logic clk,
  input  logic rst,
  input  logic [5:0] target_format,
  input  logic q_valid,
  output logic q_ready,
  input  logic [65:0] q_data,
  pfc_stream_if.source out_ch
);
  import pfc_pkg::*;
  `include "assert_macros.svh"

  layout_t tl;
  logic [63:0] pix;
  logic [15:0] fv;
  logic [15:0] cv;
  logic [31:0] prod;
  logic [32:0] quo;

  always_comb begin
    tl = lookup(target_format);
    pix = '0;
    fv = '0;
    cv = '0;
    prod = '0;
    quo = '0;
    for (int c = 0; c < 4; c++) begin
      // (v * mask) / 65535 with mask = 2^w - 1: v * mask by shift and subtract,
      // the division by 2^16 - 1 as (x + (x >> 16) + 1) >> 16
      cv = q_data[16*c +: 16];
      prod = ({16'd0, cv} << tl.fld[c].wid) - {16'd0, cv};
      quo = ({1'b0, prod} + {17'd0, prod[31:16]} + 33'd1) >> 16;
      fv = quo[15:0];
      if (3'(c) < tl.chans) begin
        pix = pix | (64'(fv & wmask(tl.fld[c].wid)) << tl.fld[c].off);
      end
    end
    if (!q_data[64]) begin
      pix = '0;
    end
  end

  logic v;
  assign q_ready = !v || out_ch.ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (q_ready) begin
      v <= q_valid;
    end
    if (q_ready && q_valid) begin
      out_ch.pixel <= pix;
      out_ch.last <= q_data[65];
    end
  end
  assign out_ch.valid = v;

  `CHECK_CLK(a_hold, v && !out_ch.ready |=> v, "output dropped while stalled")
  `CHECK_CLK(a_load, q_valid && q_ready |=> v, "accepted entry not shown")
  `CHECK_ALWAYS(a_rst, rst |=> !v, "output valid after reset")
endmodule

/* rtl/pixel_format_converter_unit.sv */
// pixel format converter
// in_ch: source pixel (64 bits little-endian) plus a row-end flag, valid/ready.
// out_ch: converted pixel with the flag copied, valid/ready; bytes past the
//   target size are zero, an out-of-range format gives a zero pixel.
// apb: four registers at byte addresses 0, 4, 8, 12: source format,
//   target format, source no-alpha, target no-alpha; write only while idle.
// path: an accepted pixel passes the front register, the two-entry queue
//   and the output register in that order.
// throughput: one pixel per clock unless out_ch stalls; front and back are
//   each one pass of table lookup plus shift/replicate/add, no multipliers.
// reset: formats go to 9 (32-bit RGBA), no-alpha bits clear, all stages empty.
// stall: when the output is not taken, the output register holds, the queue
//   fills, then the front and finally in_ch.ready drop; nothing is lost.
module pixel_format_converter_unit (
  input  logic clk,
  input  logic rst,
  pfc_stream_if.sink in_ch,
  pfc_stream_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import pfc_pkg::*;

  logic [5:0] source_format;
  logic [5:0] target_format;
  logic source_no_alpha;
  logic target_no_alpha;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx = reg_idx_t'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= 6'd9;
      target_format <= 6'd9;
      source_no_alpha <= 1'b0;
      target_no_alpha <= 1'b0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (idx)
        REG_SRC_FMT: source_format <= pwdata[5:0];
        REG_DST_FMT: target_format <= pwdata[5:0];
        REG_SRC_NOA: source_no_alpha <= pwdata[0];
        REG_DST_NOA: target_no_alpha <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (idx)
      REG_SRC_FMT: prdata = {26'd0, source_format};
      REG_DST_FMT: prdata = {26'd0, target_format};
      REG_SRC_NOA: prdata = {31'd0, source_no_alpha};
      REG_DST_NOA: prdata = {31'd0, target_no_alpha};
      default: prdata = '0;
    endcase
  end

  logic fv, fr, bv, br;
  logic [65:0] fd, bd;

  pfc_front u_front (
    .clk, .rst, .source_format, .target_format, .source_no_alpha, .target_no_alpha,
    .in_ch, .q_ready(fr), .q_valid(fv), .q_data(fd)
  );

  pfc_fifo u_fifo (
    .clk, .rst, .wvalid(fv), .wready(fr), .wdata(fd),
    .rvalid(bv), .rready(br), .rdata(bd)
  );

  pfc_back u_back (
    .clk, .rst, .target_format, .q_valid(bv), .q_ready(br), .q_data(bd), .out_ch
  );
endmodule
